// ===== rtl/med3x3_pkg.sv =====
// Shared types and constants of the 3x3 median filter.
`default_nettype none
package med3x3_pkg;

    localparam int PIX_W      = 16;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int Q_DEPTH    = 8;
    localparam int Q_PTR_W    = 3;
    localparam int Q_CNT_W    = 4;

    localparam logic ACTION_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAST_COLUMN = 2'd0,
        CFG_LAST_ROW    = 2'd1,
        CFG_SAMPLE_MODE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] median;
        logic             row_end;
        logic             frame_end;
        logic             last;
    } result_t;

    typedef struct packed {
        logic mid;
        logic up;
    } store_wr_t;

endpackage
`default_nettype wire

// ===== rtl/med3x3_median9.sv =====
// Compare-exchange network giving the median of nine samples.
`default_nettype none
module med3x3_median9 #(
    parameter int W = 16
) (
    input  wire logic [8:0][W-1:0] v,
    output logic       [W-1:0]     median
);

    function automatic logic [W-1:0] mn(input logic [W-1:0] x, input logic [W-1:0] y);
        return (x > y) ? y : x;
    endfunction

    function automatic logic [W-1:0] mx(input logic [W-1:0] x, input logic [W-1:0] y);
        return (x > y) ? x : y;
    endfunction

    logic [W-1:0] a0, a1, a2, a3, a4;
    logic [W-1:0] b0, b1, b2, b3, b4;
    logic [W-1:0] c0, c1, c2, c3;
    logic [W-1:0] d0, d1, d2, d3;
    logic [W-1:0] e0, e1, e2;
    logic [W-1:0] f0, f1, f2;
    logic [W-1:0] g0, g1, g2;
    logic [W-1:0] h0, h1;

    always_comb
    begin
        a0 = mn(v[1], v[2]);
        b0 = mx(v[1], v[2]);
        a1 = mn(a0, v[0]);
        c0 = mx(a0, v[0]);
        b1 = mn(b0, c0);
        c1 = mx(b0, c0);
        d0 = mn(v[4], v[5]);
        e0 = mx(v[4], v[5]);
        d1 = mn(d0, v[3]);
        f0 = mx(d0, v[3]);
        e1 = mn(e0, f0);
        f1 = mx(e0, f0);
        a2 = mx(a1, d1);
        d2 = mn(v[7], v[8]);
        g0 = mx(v[7], v[8]);
        d3 = mn(d2, v[6]);
        h0 = mx(d2, v[6]);
        a3 = mx(a2, d3);
        g1 = mn(g0, h0);
        h1 = mx(g0, h0);
        e2 = mn(e1, g1);
        g2 = mx(e1, g1);
        b2 = mx(b1, e2);
        b3 = mn(b2, g2);
        f2 = mn(f1, h1);
        c2 = mn(c1, f2);
        b4 = mn(b3, c2);
        c3 = mx(b3, c2);
        a4 = mx(a3, b4);
        median = mn(a4, c3);
    end

endmodule
`default_nettype wire

// ===== rtl/med3x3_row_stores.sv =====
// Upper and middle row stores with registered read ports.
`default_nettype none
module med3x3_row_stores #(
    parameter int W     = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_idx,
    input  wire med3x3_pkg::store_wr_t    wr,
    input  wire logic [$clog2(DEPTH)-1:0] wr_idx,
    input  wire logic [W-1:0]             wr_mid_data,
    input  wire logic [W-1:0]             wr_up_data,
    output logic      [W-1:0]             rd_mid,
    output logic      [W-1:0]             rd_up
);
    import med3x3_pkg::*;

    logic [W-1:0] mid_mem [DEPTH];
    logic [W-1:0] up_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.mid)
        begin
            mid_mem[wr_idx] <= wr_mid_data;
        end
        if (rd_en)
        begin
            rd_mid <= mid_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.up)
        begin
            up_mem[wr_idx] <= wr_up_data;
        end
        if (rd_en)
        begin
            rd_up <= up_mem[rd_idx];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/med3x3_out_queue.sv =====
// Result queue taking up to two results a cycle and giving one while head_stall is low.
`default_nettype none
module med3x3_out_queue (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_first_valid,
    input  wire med3x3_pkg::result_t            wr_first,
    input  wire logic                           wr_second_valid,
    input  wire med3x3_pkg::result_t            wr_second,
    input  wire logic                           head_stall,
    output logic                                head_valid,
    output med3x3_pkg::result_t                 head,
    output logic [med3x3_pkg::Q_CNT_W-1:0]      count
);
    import med3x3_pkg::*;

    result_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]    count_reg, count_next;
    logic                  put0, put1, pop;
    result_t               put0_data;
    logic [Q_CNT_W-1:0]    put_n;

    always_comb
    begin
        put0      = wr_first_valid | wr_second_valid;
        put1      = wr_first_valid & wr_second_valid;
        put0_data = wr_first_valid ? wr_first : wr_second;
        put_n     = Q_CNT_W'(put0) + Q_CNT_W'(put1);
        pop       = (count_reg != '0) && !head_stall;
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(put_n);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
        count_next  = count_reg + put_n - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (put0)
        begin
            entry_reg[wr_ptr_reg] <= put0_data;
        end
        if (put1)
        begin
            entry_reg[Q_PTR_W'(wr_ptr_reg + 1'b1)] <= wr_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule
`default_nettype wire

// ===== rtl/median_3x3_filter_unit.sv =====
// Top level of the 3x3 median filter with replicated borders.
`default_nettype none
// The unit takes one item per clock while feed_stall is low and gives, one row behind the
// input, the median of each pixel's 3x3 neighbourhood with border pixels replicated. Pixels of
// the first row give no result; a pixel at the last column gives two results unless it is also
// the first column, and a frame is drained by one flush item per column. An accepted item passes
// the column stage registers, its results are written into the result queue, and the queue head
// offers them, a second result from the same item after the first. The rate of one item per
// cycle is set by the single read port of each row store and the one-pass sorting network;
// feed_stall rises when the result queue, counting the results still on their way into it,
// holds more than six, so that the two results of a further item might find no room.
module median_3x3_filter_unit #(
    parameter int MAX_WIDTH   = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [med3x3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [med3x3_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                                feed_valid,
    output logic                                     feed_stall,
    input  wire logic                                action,
    input  wire logic [med3x3_pkg::PIX_W-1:0]        pixel,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic [med3x3_pkg::PIX_W-1:0]             median,
    output logic                                     row_end,
    output logic                                     frame_end,
    output logic                                     last
);
    import med3x3_pkg::*;

    localparam int W     = SAMPLE_BITS;
    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_WIDTH - 1);
    localparam logic [Q_CNT_W:0] ROOM_LIMIT = (Q_CNT_W + 1)'(Q_DEPTH - 2);

    logic [COL_W-1:0] last_column_reg;
    logic [ROW_W-1:0] last_row_reg;
    logic             sample_mode_reg;

    logic [COL_W-1:0] column_count_reg, column_count_next;
    logic [COL_W-1:0] flush_count_reg, flush_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [IDX_W-1:0] col_idx_reg, col_idx_next;
    logic [IDX_W-1:0] flush_idx_reg, flush_idx_next;

    logic             accept, is_flush, at_end;
    logic [COL_W-1:0] cur_c;
    logic [IDX_W-1:0] cur_idx, cur_idx_inc;
    logic [COL_W-1:0] cur_c_inc;
    logic [ROW_W-1:0] row_prev;
    logic [W-1:0]     p;

    logic             b_valid_reg;
    logic             b_flush_reg, b_active_reg, b_left_reg, b_ge2_reg, b_at_end_reg;
    logic             b_r0_reg, b_frame_end_reg, b_hz_mid_reg, b_hz_up_reg;
    store_wr_t        b_wr_reg;
    logic [IDX_W-1:0] b_idx_reg;
    logic [W-1:0]     b_p_reg, b_byp_mid_reg, b_byp_up_reg;

    logic [W-1:0]     rd_mid, rd_up, col0, col1, col2, up_val;
    logic [W-1:0]     win_cur_reg [3];
    logic [W-1:0]     win_prev_reg [3];
    store_wr_t        store_wr;

    logic [8:0][W-1:0] v_left, v_end;
    logic [W-1:0]      med_left, med_end;
    logic              push_left, push_end;
    result_t           res_left, res_end, head;
    logic [Q_CNT_W-1:0] q_count;
    logic [Q_CNT_W:0]  pending;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_column_reg <= COL_W'(2047);
            last_row_reg    <= ROW_W'(1079);
            sample_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LAST_COLUMN: last_column_reg <= cfg_data[COL_W-1:0];
                CFG_LAST_ROW:    last_row_reg    <= cfg_data[ROW_W-1:0];
                CFG_SAMPLE_MODE: sample_mode_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Position counters and the accept stage.
    assign pending    = (Q_CNT_W + 1)'(q_count)
                      + (Q_CNT_W + 1)'(b_valid_reg & b_active_reg & b_left_reg)
                      + (Q_CNT_W + 1)'(b_valid_reg & b_active_reg & b_at_end_reg);
    assign feed_stall = (pending > ROOM_LIMIT);
    assign accept     = feed_valid && !feed_stall;

    always_comb
    begin
        is_flush    = (action == ACTION_FLUSH);
        cur_c       = is_flush ? flush_count_reg : column_count_reg;
        cur_idx     = is_flush ? flush_idx_reg : col_idx_reg;
        at_end      = (cur_c >= last_column_reg);
        cur_c_inc   = cur_c + 1'b1;
        cur_idx_inc = (cur_idx == IDX_LAST) ? '0 : IDX_W'(cur_idx + 1'b1);
        row_prev    = row_count_reg - 1'b1;
        p           = sample_mode_reg ? pixel[W-1:0] : W'(pixel[7:0]);

        column_count_next = column_count_reg;
        flush_count_next  = flush_count_reg;
        row_count_next    = row_count_reg;
        col_idx_next      = col_idx_reg;
        flush_idx_next    = flush_idx_reg;
        if (accept)
        begin
            if (is_flush)
            begin
                flush_count_next = at_end ? '0 : cur_c_inc;
                flush_idx_next   = at_end ? '0 : cur_idx_inc;
            end
            else
            begin
                column_count_next = at_end ? '0 : cur_c_inc;
                col_idx_next      = at_end ? '0 : cur_idx_inc;
                if (at_end)
                begin
                    row_count_next = (row_count_reg >= last_row_reg) ? '0
                                   : ROW_W'(row_count_reg + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            flush_count_reg  <= '0;
            row_count_reg    <= '0;
            col_idx_reg      <= '0;
            flush_idx_reg    <= '0;
            b_valid_reg      <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            flush_count_reg  <= flush_count_next;
            row_count_reg    <= row_count_next;
            col_idx_reg      <= col_idx_next;
            flush_idx_reg    <= flush_idx_next;
            b_valid_reg      <= accept;
        end
    end

    // A store write from the item just ahead lands at the same edge as this item's read,
    // so its data is carried along instead.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_flush_reg     <= is_flush;
            b_active_reg    <= is_flush || (row_count_reg != '0);
            b_left_reg      <= (cur_c != '0);
            b_ge2_reg       <= (cur_c >= COL_W'(2));
            b_at_end_reg    <= at_end;
            b_r0_reg        <= is_flush ? (last_row_reg == '0) : (row_prev == '0);
            b_frame_end_reg <= is_flush || (row_prev == last_row_reg);
            b_wr_reg.mid    <= !is_flush;
            b_wr_reg.up     <= !is_flush && (row_count_reg != '0);
            b_idx_reg       <= cur_idx;
            b_p_reg         <= p;
            b_hz_mid_reg    <= b_valid_reg && b_wr_reg.mid && (b_idx_reg == cur_idx);
            b_hz_up_reg     <= b_valid_reg && b_wr_reg.up && (b_idx_reg == cur_idx);
            b_byp_mid_reg   <= b_p_reg;
            b_byp_up_reg    <= col1;
        end
    end

    assign store_wr.mid = b_valid_reg && b_wr_reg.mid;
    assign store_wr.up  = b_valid_reg && b_wr_reg.up;

    med3x3_row_stores #(
        .W     (W),
        .DEPTH (MAX_WIDTH)
    ) u_row_stores (
        .clk         (clk),
        .rd_en       (accept),
        .rd_idx      (cur_idx),
        .wr          (store_wr),
        .wr_idx      (b_idx_reg),
        .wr_mid_data (b_p_reg),
        .wr_up_data  (col1),
        .rd_mid      (rd_mid),
        .rd_up       (rd_up)
    );

    // Column assembly and window.
    always_comb
    begin
        col1   = b_hz_mid_reg ? b_byp_mid_reg : rd_mid;
        up_val = b_hz_up_reg ? b_byp_up_reg : rd_up;
        col0   = b_r0_reg ? col1 : up_val;
        col2   = b_flush_reg ? col1 : b_p_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_cur_reg[i]  <= '0;
                win_prev_reg[i] <= '0;
            end
        end
        else if (b_valid_reg && b_active_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_prev_reg[i] <= win_cur_reg[i];
            end
            win_cur_reg[0] <= col0;
            win_cur_reg[1] <= col1;
            win_cur_reg[2] <= col2;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v_left[i*3 + 0] = b_ge2_reg ? win_prev_reg[i] : win_cur_reg[i];
            v_left[i*3 + 1] = win_cur_reg[i];
        end
        v_left[2] = col0;
        v_left[5] = col1;
        v_left[8] = col2;

        v_end[0] = b_left_reg ? win_cur_reg[0] : col0;
        v_end[3] = b_left_reg ? win_cur_reg[1] : col1;
        v_end[6] = b_left_reg ? win_cur_reg[2] : col2;
        v_end[1] = col0;
        v_end[2] = col0;
        v_end[4] = col1;
        v_end[5] = col1;
        v_end[7] = col2;
        v_end[8] = col2;
    end

    med3x3_median9 #(.W(W)) u_median_left (.v(v_left), .median(med_left));
    med3x3_median9 #(.W(W)) u_median_end  (.v(v_end),  .median(med_end));

    always_comb
    begin
        push_left = b_valid_reg && b_active_reg && b_left_reg;
        push_end  = b_valid_reg && b_active_reg && b_at_end_reg;

        res_left.median    = PIX_W'(med_left);
        res_left.row_end   = 1'b0;
        res_left.frame_end = 1'b0;
        res_left.last      = !push_end;

        res_end.median     = PIX_W'(med_end);
        res_end.row_end    = 1'b1;
        res_end.frame_end  = b_frame_end_reg;
        res_end.last       = 1'b1;
    end

    med3x3_out_queue u_out_queue (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_first_valid  (push_left),
        .wr_first        (res_left),
        .wr_second_valid (push_end),
        .wr_second       (res_end),
        .head_stall      (result_stall),
        .head_valid      (result_valid),
        .head            (head),
        .count           (q_count)
    );

    assign median    = head.median;
    assign row_end   = head.row_end;
    assign frame_end = head.frame_end;
    assign last      = head.last;

    // An accepted item is always worked on in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> b_valid_reg)
        else $error("accepted item did not reach the column stage");

    // Results of the item in the column stage always find room in the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (pending <= (Q_CNT_W + 1)'(Q_DEPTH)))
        else $error("result queue would overflow");

    // An upper-store forward only happens together with a middle-store forward.
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_hz_up_reg) |-> b_hz_mid_reg)
        else $error("upper store forwarded without middle store");

endmodule
`default_nettype wire

// ===== tb/median_3x3_filter_unit_test.sv =====
// Self-checking testbench of the 3x3 median filter unit, with its own prediction of every result.
module median_3x3_filter_unit_test;

    import med3x3_pkg::*;

    localparam logic ACTION_PIXEL = 1'b0;
    localparam logic [8:0][PIX_W-1:0] CORNER_PIXELS = {
        16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h8001,
        16'h7FFE, 16'h5A5A, 16'hA5A5, 16'h0100
    };

    typedef struct packed {
        logic             act;
        logic [PIX_W-1:0] pix;
    } feed_item_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    cfg_index_t       cfg_index = CFG_LAST_COLUMN;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic             feed_valid = 1'b0;
    logic             feed_stall;
    logic             action = ACTION_PIXEL;
    logic [PIX_W-1:0] pixel = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    logic [PIX_W-1:0] median;
    logic             row_end;
    logic             frame_end;
    logic             last;

    // Register copies used by the predictor; the limits are shared with the stimulus planner.
    logic [COL_W-1:0] lim_col = 11'd2047;
    logic [ROW_W-1:0] lim_row = 12'd1079;
    logic             wide = 1'b0;

    logic [PIX_W-1:0] upper_row [0:2047];
    logic [PIX_W-1:0] middle_row [0:2047];
    logic [2:0][PIX_W-1:0] win_prev = '0;
    logic [2:0][PIX_W-1:0] win_older = '0;
    logic [COL_W-1:0] col_cnt = '0;
    logic [ROW_W-1:0] row_cnt = '0;
    logic [COL_W-1:0] fl_cnt = '0;

    bit               mid_filled [0:2047];
    bit               up_filled [0:2047];
    logic [COL_W-1:0] plan_col = '0;
    logic [ROW_W-1:0] plan_row = '0;
    logic [COL_W-1:0] plan_flush = '0;
    int               planned = 0;

    feed_item_t       feed_plan [$];
    feed_item_t       next_item;
    result_t          medians_due [$];
    result_t          seen;
    result_t          wanted;
    bit               feed_taken = 1'b0;
    bit               quiet = 1'b0;
    int               feed_hold = 0;
    int               stall_left = 0;
    int               errors = 0;

    median_3x3_filter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .feed_valid   (feed_valid),
        .feed_stall   (feed_stall),
        .action       (action),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .median       (median),
        .row_end      (row_end),
        .frame_end    (frame_end),
        .last         (last)
    );

    always #5 clk = ~clk;

    function automatic logic [PIX_W-1:0] middle_of_nine(input logic [8:0][PIX_W-1:0] v);
        logic [PIX_W-1:0] t;
        for (int i = 1; i < 9; i++)
        begin
            for (int j = i; j > 0 && v[j-1] > v[j]; j--)
            begin
                t = v[j];
                v[j] = v[j-1];
                v[j-1] = t;
            end
        end
        return v[4];
    endfunction

    function automatic void filter_item(input logic act, input logic [PIX_W-1:0] pix);
        logic [PIX_W-1:0] p;
        logic [COL_W-1:0] c;
        logic [ROW_W-1:0] r;
        logic             at_end;
        logic             live;
        logic [2:0][PIX_W-1:0] cur;
        logic [2:0][PIX_W-1:0] left;
        result_t          res;
        p = wide ? pix : {8'h00, pix[7:0]};
        c = (act == ACTION_FLUSH) ? fl_cnt : col_cnt;
        at_end = c >= lim_col;
        live = 1'b1;
        r = '0;
        cur = '0;
        if (act == ACTION_FLUSH)
        begin
            r = lim_row;
            cur[1] = middle_row[c];
            cur[0] = (r == 0) ? cur[1] : upper_row[c];
            cur[2] = cur[1];
            fl_cnt = at_end ? '0 : c + 1'b1;
        end
        else
        begin
            if (row_cnt == 0)
            begin
                middle_row[c] = p;
                live = 1'b0;
            end
            else
            begin
                r = row_cnt - 1'b1;
                cur[1] = middle_row[c];
                cur[0] = (r == 0) ? cur[1] : upper_row[c];
                cur[2] = p;
                upper_row[c] = cur[1];
                middle_row[c] = p;
            end
            if (at_end)
            begin
                col_cnt = '0;
                row_cnt = (row_cnt >= lim_row) ? '0 : row_cnt + 1'b1;
            end
            else
            begin
                col_cnt = c + 1'b1;
            end
        end
        if (live)
        begin
            if (c != 0)
            begin
                left = (c >= 2) ? win_older : win_prev;
                res.median = middle_of_nine({left, win_prev, cur});
                res.row_end = 1'b0;
                res.frame_end = 1'b0;
                res.last = !at_end;
                medians_due.push_back(res);
            end
            if (at_end)
            begin
                left = (c >= 1) ? win_prev : cur;
                res.median = middle_of_nine({left, cur, cur});
                res.row_end = 1'b1;
                res.frame_end = (r == lim_row);
                res.last = 1'b1;
                medians_due.push_back(res);
            end
            win_older = win_prev;
            win_prev = cur;
        end
    endfunction

    // An item that would read a row store entry never written is dropped here.
    function automatic void schedule_item(input logic act, input logic [PIX_W-1:0] pix);
        logic [COL_W-1:0] c;
        c = (act == ACTION_FLUSH) ? plan_flush : plan_col;
        if (act == ACTION_FLUSH)
        begin
            if (!mid_filled[c] || (lim_row != 0 && !up_filled[c]))
                return;
            plan_flush = (c >= lim_col) ? '0 : c + 1'b1;
        end
        else
        begin
            if (plan_row != 0)
            begin
                if (!mid_filled[c] || (plan_row != 1 && !up_filled[c]))
                    return;
                up_filled[c] = 1'b1;
            end
            mid_filled[c] = 1'b1;
            if (c >= lim_col)
            begin
                plan_col = '0;
                plan_row = (plan_row >= lim_row) ? '0 : plan_row + 1'b1;
            end
            else
            begin
                plan_col = c + 1'b1;
            end
        end
        feed_plan.push_back({act, pix});
        planned++;
    endfunction

    function automatic logic [PIX_W-1:0] sample_value();
        case ($urandom_range(0, 3))
            0: return PIX_W'($urandom_range(0, 3));
            1: return PIX_W'(32'hFFFF - $urandom_range(0, 3));
            default: return PIX_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void finish_frame();
        int guard;
        guard = 0;
        while ((plan_col != 0 || plan_row != 0) && guard < 10000)
        begin
            schedule_item(ACTION_PIXEL, sample_value());
            guard++;
        end
    endfunction

    task automatic drain();
        do
            @(posedge clk);
        while (feed_plan.size() != 0 || feed_valid || medians_due.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_LAST_COLUMN: lim_col = value[COL_W-1:0];
            CFG_LAST_ROW:    lim_row = value[ROW_W-1:0];
            CFG_SAMPLE_MODE: wide = value[0];
            default:         wide = wide;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [COL_W-1:0] lc, input logic [ROW_W-1:0] lr,
                             input logic mode);
        drain();
        write_reg(CFG_LAST_COLUMN, CFG_DATA_W'(lc));
        write_reg(CFG_LAST_ROW, lr);
        write_reg(CFG_SAMPLE_MODE, CFG_DATA_W'(mode));
    endtask

    always @(posedge clk)
    begin
        feed_taken = rst_n && feed_valid && !feed_stall;
        if (feed_taken)
            filter_item(action, pixel);
    end

    always @(negedge clk)
    begin
        if (rst_n && (!feed_valid || feed_taken))
        begin
            if (feed_hold != 0)
            begin
                feed_valid <= 1'b0;
                feed_hold <= feed_hold - 1;
            end
            else if (feed_plan.size() != 0)
            begin
                next_item = feed_plan.pop_front();
                action <= next_item.act;
                pixel <= next_item.pix;
                feed_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    feed_hold <= $urandom_range(1, 18);
            end
            else
            begin
                feed_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            result_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 9) == 0)
                stall_left <= $urandom_range(1, 18);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            seen = {median, row_end, frame_end, last};
            if (medians_due.size() == 0)
            begin
                $display("%0t: unexpected result: median %h row_end %b frame_end %b last %b",
                         $time, seen.median, seen.row_end, seen.frame_end, seen.last);
                errors++;
            end
            else
            begin
                wanted = medians_due.pop_front();
                if (seen !== wanted)
                begin
                    $display("%0t: expected median %h row_end %b frame_end %b last %b",
                             $time, wanted.median, wanted.row_end, wanted.frame_end,
                             wanted.last);
                    $display("%0t:   actual median %h row_end %b frame_end %b last %b",
                             $time, seen.median, seen.row_end, seen.frame_end, seen.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int               random_count;
        int               first;
        logic [COL_W-1:0] lc;
        logic [ROW_W-1:0] lr;
        random_count = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A 3x3 frame of corner values in 8-bit mode, then the flush row.
        configure(11'd2, 12'd2, 1'b0);
        for (int i = 0; i < 9; i++)
            schedule_item(ACTION_PIXEL, CORNER_PIXELS[i]);
        repeat (3) schedule_item(ACTION_FLUSH, 16'hFFFF);

        // Single-column rows.
        configure(11'd0, 12'd1, 1'b1);
        schedule_item(ACTION_PIXEL, 16'hFFFF);
        schedule_item(ACTION_PIXEL, 16'h8000);
        schedule_item(ACTION_FLUSH, 16'hFFFF);

        // Flush items mixed into a frame.
        configure(11'd1, 12'd1, 1'b1);
        schedule_item(ACTION_PIXEL, 16'h1234);
        schedule_item(ACTION_PIXEL, 16'hFFFF);
        schedule_item(ACTION_FLUSH, 16'h0000);
        schedule_item(ACTION_PIXEL, 16'h0000);
        schedule_item(ACTION_PIXEL, 16'h0007);
        schedule_item(ACTION_FLUSH, 16'h0000);
        schedule_item(ACTION_FLUSH, 16'hFFFF);

        // Widest rows, then both counters left beyond limits that shrink.
        configure(11'd2047, 12'd0, 1'b1);
        repeat (2048) schedule_item(ACTION_PIXEL, sample_value());
        repeat (20) schedule_item(ACTION_FLUSH, sample_value());
        configure(11'd5, 12'd4095, 1'b0);
        repeat (22) schedule_item(ACTION_PIXEL, sample_value());
        configure(11'd2, 12'd0, 1'b1);
        schedule_item(ACTION_PIXEL, sample_value());
        repeat (4) schedule_item(ACTION_FLUSH, sample_value());
        finish_frame();

        while (random_count < 200)
        begin
            if (plan_col == 0 && plan_row == 0)
                lc = ($urandom_range(0, 3) == 0) ? COL_W'($urandom_range(8, 40))
                                                 : COL_W'($urandom_range(0, 7));
            else
                lc = ($urandom_range(0, 2) == 0) ? COL_W'($urandom_range(0, lim_col))
                                                 : lim_col;
            lr = ($urandom_range(0, 4) == 0) ? ROW_W'($urandom_range(6, 12))
                                             : ROW_W'($urandom_range(0, 5));
            configure(lc, lr, 1'($urandom_range(0, 1)));
            first = planned;
            repeat ($urandom_range(20, 120))
                schedule_item(($urandom_range(0, 9) == 0) ? ACTION_FLUSH : ACTION_PIXEL,
                              sample_value());
            if ($urandom_range(0, 3) != 0)
            begin
                finish_frame();
                repeat (lim_col + 1) schedule_item(ACTION_FLUSH, sample_value());
            end
            random_count += planned - first;
        end

        // A last frame sent back to back with no stalls.
        quiet = 1'b1;
        configure(11'd7, 12'd3, 1'b1);
        finish_frame();
        repeat (32) schedule_item(ACTION_PIXEL, sample_value());
        repeat (8) schedule_item(ACTION_FLUSH, sample_value());

        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/med3x3_pkg.sv
rtl/med3x3_median9.sv
rtl/med3x3_row_stores.sv
rtl/med3x3_out_queue.sv
rtl/median_3x3_filter_unit.sv
tb/median_3x3_filter_unit_test.sv
